### sv/tsm_pkg.sv
package tsm_pkg;

	localparam int DEG_W  = 6;
	localparam int IDX_W  = 7;
	localparam int COEF_W = 32;
	localparam int PROD_W = 64;
	localparam int FRAC_W = 16;
	localparam int ACC_W  = 71;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_u;
		logic signed [COEF_W-1:0] coef_v;
		logic                     series_start;
	} tsm_in_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_product;
		logic [DEG_W-1:0]         coef_index;
		logic                     is_last;
		logic                     saturated;
		logic                     past_degree;
	} tsm_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} tsm_state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic load_out;
	} tsm_cmd_t;

	typedef struct packed {
		logic past;
		logic issue_last;
		logic pipe_empty;
		logic out_free;
	} tsm_sts_t;

endpackage

### sv/tsm_ctrl.sv
module tsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tsm_pkg::tsm_sts_t sts,
	output tsm_pkg::tsm_cmd_t cmd
);
	import tsm_pkg::*;

	tsm_state_t state_q;
	tsm_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = sts.past ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.issue_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.issue    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

### sv/tsm_datapath.sv
module tsm_datapath #(
	parameter int MAX_TERMS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [tsm_pkg::DEG_W-1:0] cfg_wdata,
	input  tsm_pkg::tsm_in_t         in_data,
	output tsm_pkg::tsm_out_t        out_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  tsm_pkg::tsm_cmd_t        cmd,
	output tsm_pkg::tsm_sts_t        sts
);
	import tsm_pkg::*;

	localparam int AW = $clog2(MAX_TERMS);

	logic [COEF_W-1:0] mem_u [MAX_TERMS];
	logic [COEF_W-1:0] mem_v [MAX_TERMS];

	logic [DEG_W-1:0] degree_q;
	logic [IDX_W-1:0] next_idx_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] k_q;
	logic             past_q;
	logic             last_q;
	logic             rd_vld_s1;
	logic             mul_vld_s2;
	logic             out_valid_q;

	logic signed [COEF_W-1:0] u_rd_s1;
	logic signed [COEF_W-1:0] v_rd_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	tsm_out_t                 out_q;

	logic [IDX_W-1:0] n_now;
	logic             past_now;
	logic [IDX_W-1:0] v_idx;
	logic             store;
	logic [ACC_W-FRAC_W-COEF_W:0] acc_top;
	logic             fits;
	tsm_out_t         result;

	// a start beat restarts the series at degree zero
	assign n_now    = in_data.series_start ? '0 : next_idx_q;
	assign past_now = (n_now > IDX_W'(degree_q)) || (32'(n_now) >= MAX_TERMS);
	assign store    = cmd.accept && !past_now;
	assign v_idx    = n_q - k_q;

	assign sts.past       = past_now;
	assign sts.issue_last = (k_q == n_q);
	assign sts.pipe_empty = !rd_vld_s1 && !mul_vld_s2;
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q    <= DEG_W'(10);
			next_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			mul_vld_s2  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				degree_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				next_idx_q <= past_now ? n_now : n_now + IDX_W'(1);
			end
			rd_vld_s1  <= cmd.issue;
			mul_vld_s2 <= rd_vld_s1;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			mem_u[AW'(n_now)] <= in_data.coef_u;
			mem_v[AW'(n_now)] <= in_data.coef_v;
		end
		if (cmd.issue) begin
			u_rd_s1 <= mem_u[AW'(k_q)];
			v_rd_s1 <= mem_v[AW'(v_idx)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			n_q    <= n_now;
			k_q    <= '0;
			past_q <= past_now;
			last_q <= (n_now == IDX_W'(degree_q));
		end else if (cmd.issue) begin
			k_q <= k_q + IDX_W'(1);
		end
		prod_s2 <= u_rd_s1 * v_rd_s1;
		if (cmd.accept) begin
			acc_q <= '0;
		end else if (mul_vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.load_out) begin
			out_q <= result;
		end
	end

	// shifted sum fits in 32 bits when everything above its sign bit is a copy of it
	assign acc_top = acc_q[ACC_W-1:FRAC_W+COEF_W-1];
	assign fits    = (&acc_top) || !(|acc_top);

	always_comb begin
		result = '0;
		if (past_q) begin
			result.past_degree = 1'b1;
		end else begin
			result.coef_index = n_q[DEG_W-1:0];
			result.is_last    = last_q;
			result.saturated  = !fits;
			if (fits) begin
				result.coef_product = acc_q[FRAC_W+COEF_W-1:FRAC_W];
			end else if (acc_q[ACC_W-1]) begin
				result.coef_product = {1'b1, {(COEF_W-1){1'b0}}};
			end else begin
				result.coef_product = {1'b0, {(COEF_W-1){1'b1}}};
			end
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

### sv/truncated_series_multiply.sv
// channel | direction | handshake            | payload
// cfg     | in        | cfg_we               | cfg_wdata (series_degree)
// in      | in        | in_valid / in_ready  | in_data   (coef_u, coef_v, series_start)
// out     | out       | out_valid / out_ready| out_data  (coef_product, coef_index, flags)
//
// For an item of degree n, one 32x32 multiplier steps over the n + 1 stored
// coefficient pairs, followed by the read, multiply and accumulate stages.
// An item beyond the degree is not stored.
// One item is in work at a time; the next is taken while the result waits in
// the output register. A stalled output holds the block in its last step.
// Reset sets the degree to 10 and the next index to 0; histories need no clear.
module truncated_series_multiply #(
	parameter int MAX_TERMS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tsm_pkg::DEG_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  tsm_pkg::tsm_in_t          in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output tsm_pkg::tsm_out_t         out_data
);
	import tsm_pkg::*;

	tsm_cmd_t cmd;
	tsm_sts_t sts;

	tsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tsm_datapath #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### sv/tsm_checker.sv
module tsm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input tsm_pkg::tsm_out_t         out_data
);
	import tsm_pkg::*;

	// a waiting result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	a_past_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.past_degree |->
			out_data.coef_product == '0 && out_data.coef_index == '0 &&
			!out_data.is_last && !out_data.saturated)
		else $error("dropped item returned nonzero fields");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			out_data.coef_product == 32'sh7fffffff ||
			out_data.coef_product == 32'sh80000000)
		else $error("saturated result is not a bound");

endmodule

bind truncated_series_multiply tsm_checker u_chk (.*);

### tb/sv/tb_truncated_series_multiply.sv
`timescale 1ns / 100ps

module tb_truncated_series_multiply;
	import tsm_pkg::*;

	localparam int TERMS          = 64;
	localparam int IDLE_PCT       = 36;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TARGET_PAIRS   = 950;

	localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
	localparam logic signed [127:0] Q_MIN = -Q_MAX - 128'sd1;

	class cauchy_product_model;
		logic [DEG_W-1:0]         degree;
		logic [IDX_W-1:0]         next_idx;
		logic signed [COEF_W-1:0] hist_u[TERMS];
		logic signed [COEF_W-1:0] hist_v[TERMS];
		tsm_out_t                 pending_coefs[$];
		int                       errors;
		int                       stored;
		int                       dropped;
		int                       clipped;

		function new();
			degree   = 6'd10;
			next_idx = '0;
			errors   = 0;
			stored   = 0;
			dropped  = 0;
			clipped  = 0;
		endfunction

		function void set_degree(input logic [DEG_W-1:0] d);
			degree = d;
		endfunction

		function int pending();
			return pending_coefs.size();
		endfunction

		// Note one accepted coefficient pair and queue the product it must yield.
		function void take_pair(input tsm_in_t item);
			tsm_out_t            res;
			logic [IDX_W-1:0]    n;
			logic signed [127:0] acc;
			logic signed [127:0] sh;
			longint              p;
			int                  k;
			res = '0;
			if (item.series_start)
				next_idx = '0;
			n = next_idx;
			if (n > degree || n >= TERMS) begin
				res.past_degree = 1'b1;
				pending_coefs.push_back(res);
				dropped++;
				return;
			end
			hist_u[n] = item.coef_u;
			hist_v[n] = item.coef_v;
			next_idx  = n + 1'b1;
			acc = '0;
			for (k = 0; k <= n; k++) begin
				p = longint'(hist_u[k]) * longint'(hist_v[n - k]);
				acc += 128'(p);
			end
			// arithmetic shift: rounds toward minus infinity
			sh = acc >>> FRAC_W;
			if (sh > Q_MAX) begin
				res.coef_product = 32'h7FFF_FFFF;
				res.saturated    = 1'b1;
			end else if (sh < Q_MIN) begin
				res.coef_product = 32'h8000_0000;
				res.saturated    = 1'b1;
			end else begin
				res.coef_product = sh[COEF_W-1:0];
			end
			res.coef_index = n[DEG_W-1:0];
			res.is_last    = (n == degree);
			if (res.saturated)
				clipped++;
			stored++;
			pending_coefs.push_back(res);
		endfunction

		function void compare_field(input string name, input logic [31:0] want,
				input logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_coef(input tsm_out_t got);
			tsm_out_t want;
			if (pending_coefs.size() == 0) begin
				$error("product beat with nothing pending: index %0d value %h",
					got.coef_index, got.coef_product);
				errors++;
				return;
			end
			want = pending_coefs.pop_front();
			compare_field("coef_product", want.coef_product, got.coef_product);
			compare_field("coef_index", 32'(want.coef_index), 32'(got.coef_index));
			compare_field("is_last", 32'(want.is_last), 32'(got.is_last));
			compare_field("saturated", 32'(want.saturated), 32'(got.saturated));
			compare_field("past_degree", 32'(want.past_degree), 32'(got.past_degree));
		endfunction
	endclass

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [DEG_W-1:0]  cfg_wdata = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	tsm_in_t           in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	tsm_out_t          out_data;

	bit                  no_gaps = 1'b0;
	int                  settings_written = 0;
	int                  quiet_cycles = 0;
	cauchy_product_model product_pred;

	truncated_series_multiply dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			product_pred.check_coef(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Small Q16.16 values (the largest share) so sums stay in range, plus wide, corner and random values.
	function automatic logic [31:0] pick_coef();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 32'($urandom_range(0, 262143)) - 32'd131072;
		else if (r < 55)
			return 32'($urandom_range(0, 33554431)) - 32'd16777216;
		else if (r < 70) begin
			case ($urandom_range(0, 5))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				3: return 32'hFFFF_FFFF;
				4: return 32'h0000_0001;
				default: return 32'h0001_0000;
			endcase
		end
		return $urandom();
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_pair(input logic start, input logic [31:0] u, input logic [31:0] v);
		tsm_in_t item;
		item.coef_u       = u;
		item.coef_v       = v;
		item.series_start = start;
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		product_pred.take_pair(item);
		@(negedge clk);
	endtask

	// Hold the sender until every pending product has come back.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (product_pred.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_degree(input logic [DEG_W-1:0] d);
		cfg_wdata <= d;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		product_pred.set_degree(d);
		settings_written++;
	endtask

	task automatic run_series(input int deg, input bit skip_start);
		int   len;
		int   r;
		int   i;
		logic start;
		r = $urandom_range(0, 99);
		if (r < 70)
			len = deg + 1;
		else if (r < 90)
			len = $urandom_range(1, deg + 1);
		else
			len = deg + 1 + $urandom_range(1, 3);
		for (i = 0; i < len; i++) begin
			start = (i == 0) && !skip_start;
			// occasional restart in the middle of a series
			if (i != 0 && $urandom_range(0, 99) < 2)
				start = 1'b1;
			send_pair(start, pick_coef(), pick_coef());
		end
	endtask

	initial begin
		int i;
		int ph;
		int s;
		int deg;
		product_pred = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset degree of 10; the first beat counts as degree zero without a start.
		send_pair(1'b0, 32'hFFFF_FFFF, 32'h0000_0001);
		send_pair(1'b0, 32'h0001_0000, 32'h0001_0000);
		send_pair(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pair(1'b1, 32'h8000_0000, 32'h8000_0000);
		send_pair(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
		for (i = 1; i <= 12; i++)
			send_pair(1'b0, pick_coef(), pick_coef());
		send_pair(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
		send_pair(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_pair(1'b0, 32'h0001_8000, 32'hFFFE_8000);
		wait_drain();

		// Lower the degree below the running index, then raise it to resume.
		write_degree(6'd1);
		send_pair(1'b0, pick_coef(), pick_coef());
		send_pair(1'b0, pick_coef(), pick_coef());
		wait_drain();
		write_degree(6'd12);
		send_pair(1'b0, pick_coef(), pick_coef());
		send_pair(1'b0, pick_coef(), pick_coef());
		wait_drain();

		ph = 0;
		while (product_pred.stored + product_pred.dropped < TARGET_PAIRS) begin
			case (ph % 6)
				0: deg = 63;
				1: deg = 0;
				2: deg = $urandom_range(1, 63);
				default: deg = $urandom_range(1, 12);
			endcase
			no_gaps = (ph >= 6 && ph < 10);
			write_degree(deg[DEG_W-1:0]);
			for (s = 0; s < ((deg >= 32) ? 1 : 4); s++)
				run_series(deg, (s == 0) && (ph % 7 == 3));
			wait_drain();
			ph++;
		end
		no_gaps = 1'b0;

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("run covered %0d stored coefficient pairs and %0d beats beyond degree",
			product_pred.stored, product_pred.dropped);
		$display("over %0d degree settings; %0d products clipped to 32 bits",
			settings_written, product_pred.clipped);
		if (product_pred.errors == 0 && product_pred.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
